FILE: sv/bthome_tlv_frame_decoder_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frame decoder
// Shared macros for the concurrent checks in the decoder's RTL.
// ---------------------------------------------------------------------------
`ifndef BTHOME_TLV_FRAME_DECODER_UNIT_DEFINES_SVH
`define BTHOME_TLV_FRAME_DECODER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define BTFD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that, when true, implies a consequent in the same cycle.
`define BTFD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/btfd_pkg.sv
// ---------------------------------------------------------------------------
// Frame decoder package
// Item types, field codes, outcome codes and tag values of the decoder.
// ---------------------------------------------------------------------------
package btfd_pkg;

    localparam logic [1:0]  HEADER_BYTES = 2'd3;
    localparam logic [15:0] SERVICE_UUID = 16'hFCD2;

    localparam logic [7:0] TAG_PACKET_ID   = 8'h00;
    localparam logic [7:0] TAG_BATTERY     = 8'h01;
    localparam logic [7:0] TAG_TEMPERATURE = 8'h02;
    localparam logic [7:0] TAG_HUMIDITY    = 8'h03;
    localparam logic [7:0] TAG_VOLTAGE     = 8'h0C;
    localparam logic [7:0] TAG_BINARY_A    = 8'h0F;
    localparam logic [7:0] TAG_BINARY_B    = 8'h10;
    localparam logic [7:0] TAG_BINARY_C    = 8'h11;

    typedef enum logic [2:0] {
        FLD_NONE = 3'd0,
        FLD_TEMP = 3'd1,
        FLD_HUM  = 3'd2,
        FLD_BATT = 3'd3,
        FLD_VOLT = 3'd4,
        FLD_SKIP = 3'd5
    } field_t;

    typedef enum logic [1:0] {
        OUTCOME_FOREIGN   = 2'd0,
        OUTCOME_EMPTY     = 2'd1,
        OUTCOME_READINGS  = 2'd2,
        OUTCOME_MALFORMED = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               is_last;
        logic [15:0]        frame_uuid;
        logic [47:0]        source_mac;
        logic signed [7:0]  signal_strength;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic               has_temperature;
        logic signed [15:0] temperature;
        logic               has_humidity;
        logic [15:0]        humidity;
        logic               has_battery;
        logic [7:0]         battery_percent;
        logic               has_voltage;
        logic [15:0]        voltage_mv;
        logic [47:0]        source_mac_res;
        logic signed [7:0]  signal_strength_res;
    } out_item_t;

endpackage

FILE: sv/btfd_in_if.sv
// ---------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel that carries one frame byte and its side fields.
// ---------------------------------------------------------------------------
interface btfd_in_if;
    import btfd_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: sv/btfd_out_if.sv
// ---------------------------------------------------------------------------
// Decode result channel
// Valid/ready channel that carries one decoded frame summary.
// ---------------------------------------------------------------------------
interface btfd_out_if;
    import btfd_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: sv/btfd_tlv_parser.sv
// ---------------------------------------------------------------------------
// Tag-value parser
// Holds the per-frame parse state and forms the summary on the final byte.
// ---------------------------------------------------------------------------
module btfd_tlv_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  btfd_pkg::in_item_t item,
    output btfd_pkg::out_item_t res
);
    import btfd_pkg::*;

    logic [1:0]  hdr_reg, hdr_next;
    logic [1:0]  left_reg, left_next;
    field_t      pend_reg, pend_next;
    logic [7:0]  low_reg, low_next;
    logic        stop_reg, stop_next;
    logic        found_reg, found_next;
    logic        temp_v_reg, temp_v_next;
    logic [15:0] temp_reg, temp_next;
    logic        hum_v_reg, hum_v_next;
    logic [15:0] hum_reg, hum_next;
    logic        batt_v_reg, batt_v_next;
    logic [7:0]  batt_reg, batt_next;
    logic        volt_v_reg, volt_v_next;
    logic [15:0] volt_reg, volt_next;
    logic [15:0] word;
    logic        stop_final;
    logic        report;
    outcome_t    outcome;

    assign word = {item.data_byte, low_reg};

    always_comb
    begin
        hdr_next    = hdr_reg;
        left_next   = left_reg;
        pend_next   = pend_reg;
        low_next    = low_reg;
        stop_next   = stop_reg;
        found_next  = found_reg;
        temp_v_next = temp_v_reg;
        temp_next   = temp_reg;
        hum_v_next  = hum_v_reg;
        hum_next    = hum_reg;
        batt_v_next = batt_v_reg;
        batt_next   = batt_reg;
        volt_v_next = volt_v_reg;
        volt_next   = volt_reg;

        if (hdr_reg < HEADER_BYTES)
        begin
            hdr_next = hdr_reg + 2'd1;
        end
        else if (!stop_reg)
        begin
            if (left_reg == 2'd0)
            begin
                case (item.data_byte)
                    TAG_TEMPERATURE:
                    begin
                        pend_next = FLD_TEMP;
                        left_next = 2'd2;
                    end
                    TAG_HUMIDITY:
                    begin
                        pend_next = FLD_HUM;
                        left_next = 2'd2;
                    end
                    TAG_BATTERY:
                    begin
                        pend_next = FLD_BATT;
                        left_next = 2'd1;
                    end
                    TAG_VOLTAGE:
                    begin
                        pend_next = FLD_VOLT;
                        left_next = 2'd2;
                    end
                    TAG_PACKET_ID, TAG_BINARY_A, TAG_BINARY_B, TAG_BINARY_C:
                    begin
                        pend_next = FLD_SKIP;
                        left_next = 2'd1;
                    end
                    default:
                    begin
                        stop_next = 1'b1;
                    end
                endcase
            end
            else if (left_reg == 2'd2)
            begin
                low_next  = item.data_byte;
                left_next = 2'd1;
            end
            else
            begin
                case (pend_reg)
                    FLD_TEMP:
                    begin
                        temp_v_next = 1'b1;
                        temp_next   = word;
                        found_next  = 1'b1;
                    end
                    FLD_HUM:
                    begin
                        hum_v_next = 1'b1;
                        hum_next   = word;
                        found_next = 1'b1;
                    end
                    FLD_BATT:
                    begin
                        batt_v_next = 1'b1;
                        batt_next   = item.data_byte;
                        found_next  = 1'b1;
                    end
                    FLD_VOLT:
                    begin
                        volt_v_next = 1'b1;
                        volt_next   = word;
                        found_next  = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                left_next = 2'd0;
                pend_next = FLD_NONE;
                low_next  = 8'd0;
            end
        end
    end

    // A record still owed value bytes at the frame end makes the frame malformed when no reading was found.
    assign stop_final = stop_next || (left_next != 2'd0);

    always_comb
    begin
        if (item.frame_uuid != SERVICE_UUID)
            outcome = OUTCOME_FOREIGN;
        else if (found_next)
            outcome = OUTCOME_READINGS;
        else if (stop_final)
            outcome = OUTCOME_MALFORMED;
        else
            outcome = OUTCOME_EMPTY;
    end

    assign report = (outcome == OUTCOME_READINGS);

    always_comb
    begin
        res                     = '0;
        res.outcome             = outcome;
        res.has_temperature     = report && temp_v_next;
        res.temperature         = (report && temp_v_next) ? temp_next : 16'd0;
        res.has_humidity        = report && hum_v_next;
        res.humidity            = (report && hum_v_next) ? hum_next : 16'd0;
        res.has_battery         = report && batt_v_next;
        res.battery_percent     = (report && batt_v_next) ? batt_next : 8'd0;
        res.has_voltage         = report && volt_v_next;
        res.voltage_mv          = (report && volt_v_next) ? volt_next : 16'd0;
        res.source_mac_res      = item.source_mac;
        res.signal_strength_res = item.signal_strength;
    end

    // The final byte of a frame returns every piece of state to its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg    <= 2'd0;
            left_reg   <= 2'd0;
            pend_reg   <= FLD_NONE;
            low_reg    <= 8'd0;
            stop_reg   <= 1'b0;
            found_reg  <= 1'b0;
            temp_v_reg <= 1'b0;
            temp_reg   <= 16'd0;
            hum_v_reg  <= 1'b0;
            hum_reg    <= 16'd0;
            batt_v_reg <= 1'b0;
            batt_reg   <= 8'd0;
            volt_v_reg <= 1'b0;
            volt_reg   <= 16'd0;
        end
        else if (step && item.is_last)
        begin
            hdr_reg    <= 2'd0;
            left_reg   <= 2'd0;
            pend_reg   <= FLD_NONE;
            low_reg    <= 8'd0;
            stop_reg   <= 1'b0;
            found_reg  <= 1'b0;
            temp_v_reg <= 1'b0;
            temp_reg   <= 16'd0;
            hum_v_reg  <= 1'b0;
            hum_reg    <= 16'd0;
            batt_v_reg <= 1'b0;
            batt_reg   <= 8'd0;
            volt_v_reg <= 1'b0;
            volt_reg   <= 16'd0;
        end
        else if (step)
        begin
            hdr_reg    <= hdr_next;
            left_reg   <= left_next;
            pend_reg   <= pend_next;
            low_reg    <= low_next;
            stop_reg   <= stop_next;
            found_reg  <= found_next;
            temp_v_reg <= temp_v_next;
            temp_reg   <= temp_next;
            hum_v_reg  <= hum_v_next;
            hum_reg    <= hum_next;
            batt_v_reg <= batt_v_next;
            batt_reg   <= batt_next;
            volt_v_reg <= volt_v_next;
            volt_reg   <= volt_next;
        end
    end

endmodule

FILE: sv/bthome_tlv_frame_decoder_unit.sv
// ---------------------------------------------------------------------------
// Service-data tag-value frame decoder
// Parses a byte stream of advertisement frames and reports one summary
// item per frame.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Item carries
//  --------+-----------+---------------------------------------------------
//  frame   | in        | data_byte, is_last, frame_uuid, source_mac, rssi
//  result  | out       | outcome, readings with presence flags, address, rssi
//
// One byte item is taken per clock cycle unless a final byte waits behind
// a stalled result. The parser updates its per-frame state as a byte
// leaves the input register, and the final byte of a frame loads the
// result register, from which its summary is offered. Reset clears the
// parse state and both valid flags; payload registers are left alone. A
// stalled result blocks the input only when a final byte waits behind it;
// bytes that end no frame do not wait for the result.
//
`include "bthome_tlv_frame_decoder_unit_defines.svh"

module bthome_tlv_frame_decoder_unit (
    input logic        clk,
    input logic        rst_n,
    btfd_in_if.sink    frame,
    btfd_out_if.source result
);
    import btfd_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    out_item_t parse_res;
    logic      out_free;
    logic      in_fire;
    logic      in_take;
    logic      out_load;

    // The result register can take a new summary when empty or being emptied.
    assign out_free = !out_valid_reg || result.ready;

    // Bytes that end no frame produce no summary, so they never wait.
    assign in_fire  = in_valid_reg && (!in_item_reg.is_last || out_free);
    assign out_load = in_fire && in_item_reg.is_last;

    assign frame.ready = !in_valid_reg || in_fire;
    assign in_take     = frame.valid && frame.ready;

    assign result.valid = out_valid_reg;
    assign result.item  = out_item_reg;

    btfd_tlv_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_fire),
        .item  (in_item_reg),
        .res   (parse_res)
    );

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (in_fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= frame.item;
        if (out_load)
            out_item_reg <= parse_res;
    end

    // Only the final byte of a frame may load a summary.
    `BTFD_ASSERT_IMPLY(a_load_on_last, out_load,
        in_valid_reg && in_item_reg.is_last,
        "summary loaded from a byte that ends no frame")

    // Back-pressure upstream only comes from a final byte stuck behind a full result.
    `BTFD_ASSERT_IMPLY(a_stall_cause, !frame.ready,
        in_valid_reg && in_item_reg.is_last && out_valid_reg && !result.ready,
        "input stalled without a waiting summary")

    // Readings are reported only with the readings outcome.
    `BTFD_ASSERT_IMPLY(a_flags_need_readings,
        out_valid_reg && (out_item_reg.outcome != OUTCOME_READINGS),
        !out_item_reg.has_temperature && !out_item_reg.has_humidity &&
        !out_item_reg.has_battery && !out_item_reg.has_voltage,
        "presence flag set without readings outcome")

endmodule
